// File: rtl/core/serial_frame_receiver_checksum_top_defines.svh
// Assertion helpers used by the checker in sfrc_checker.sv.
`ifndef SERIAL_FRAME_RECEIVER_CHECKSUM_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CHECKSUM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sfrc_pkg.sv
package sfrc_pkg;

    localparam int FRAME_MAX_DEF = 16;
    localparam int DATA_W        = 8;
    localparam int IDX_W         = 6;
    localparam int TDATA_W       = 32;

    // Fixed byte positions inside a frame
    localparam int POS_ID   = 2;
    localparam int POS_SIZE = 3;
    localparam int POS_CHK  = 4;
    localparam int POS_MODE = 5;
    localparam int HDR_LEN  = 4;

    localparam logic [7:0] START_FIRST_RST  = 8'hFF;
    localparam logic [7:0] START_SECOND_RST = 8'hFE;

    // Register index, taken from paddr[2]
    localparam logic REG_START_FIRST  = 1'b0;
    localparam logic REG_START_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CHKSUM   = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic clr;
        logic add;
    } acc_ctrl_t;

endpackage

// File: rtl/core/sfrc_store.sv
module sfrc_store #(
    parameter int FRAME_MAX = sfrc_pkg::FRAME_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(FRAME_MAX)-1:0]      waddr,
    input  logic [sfrc_pkg::DATA_W-1:0]       wdata,
    input  logic                              re,
    input  logic [$clog2(FRAME_MAX)-1:0]      raddr,
    output logic [sfrc_pkg::DATA_W-1:0]       rdata
);

    logic [sfrc_pkg::DATA_W-1:0] mem [FRAME_MAX];
    logic [sfrc_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sfrc_acc.sv
module sfrc_acc (
    input  logic                          clk,
    input  sfrc_pkg::acc_ctrl_t           ctrl,
    input  logic [sfrc_pkg::DATA_W-1:0]   operand,
    input  logic [sfrc_pkg::DATA_W-1:0]   chk,
    output logic                          match
);

    logic [sfrc_pkg::DATA_W-1:0] acc_reg;
    logic [sfrc_pkg::DATA_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.add)
        begin
            acc_next = acc_reg + operand;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // checksum is the inverted byte sum
    assign match = (~acc_reg == chk);

endmodule

// File: rtl/core/sfrc_ctrl.sv
module sfrc_ctrl #(
    parameter int FRAME_MAX = sfrc_pkg::FRAME_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sfrc_pkg::DATA_W-1:0]       start_first,
    input  logic [sfrc_pkg::DATA_W-1:0]       start_second,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sfrc_pkg::DATA_W-1:0]       s_rx_byte,
    output logic                              mem_we,
    output logic [$clog2(FRAME_MAX)-1:0]      mem_waddr,
    output logic [sfrc_pkg::DATA_W-1:0]       mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(FRAME_MAX)-1:0]      mem_raddr,
    input  logic [sfrc_pkg::DATA_W-1:0]       mem_rdata,
    output sfrc_pkg::acc_ctrl_t               acc_ctrl,
    output logic [sfrc_pkg::DATA_W-1:0]       acc_chk,
    input  logic                              acc_match,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sfrc_pkg::DATA_W-1:0]       m_frame_byte,
    output logic [sfrc_pkg::IDX_W-1:0]        m_byte_index,
    output logic                              m_tlast,
    output sfrc_pkg::status_t                 m_status,
    output logic [sfrc_pkg::DATA_W-1:0]       m_device_id,
    output logic [sfrc_pkg::DATA_W-1:0]       m_frame_mode
);

    localparam int AW    = $clog2(FRAME_MAX);
    localparam int LEN_W = $clog2(FRAME_MAX + 1);
    localparam int SUM_W = sfrc_pkg::DATA_W + 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SUM_RD  = 7'b0000010,
        S_SUM_ADD = 7'b0000100,
        S_CHECK   = 7'b0001000,
        S_READ    = 7'b0010000,
        S_EMIT    = 7'b0100000,
        S_STATUS  = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [sfrc_pkg::DATA_W-1:0]  prev_reg, prev_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic [LEN_W-1:0]             idx_reg, idx_next;
    logic [sfrc_pkg::DATA_W-1:0]  b0_reg, b0_next;
    logic [sfrc_pkg::DATA_W-1:0]  b1_reg, b1_next;
    logic [sfrc_pkg::DATA_W-1:0]  id_reg, id_next;
    logic [sfrc_pkg::DATA_W-1:0]  size_reg, size_next;
    logic [sfrc_pkg::DATA_W-1:0]  chk_reg, chk_next;
    logic [sfrc_pkg::DATA_W-1:0]  mode_reg, mode_next;
    sfrc_pkg::status_t            sts_reg, sts_next;

    logic                         ov_reg, ov_next;
    logic [sfrc_pkg::DATA_W-1:0]  ob_reg, ob_next;
    logic [sfrc_pkg::IDX_W-1:0]   oi_reg, oi_next;
    logic                         ol_reg, ol_next;
    sfrc_pkg::status_t            os_reg, os_next;
    logic [sfrc_pkg::DATA_W-1:0]  oid_reg, oid_next;
    logic [sfrc_pkg::DATA_W-1:0]  omode_reg, omode_next;

    logic                         slot_free;
    logic                         start_pair;
    logic [LEN_W-1:0]             len_acc;
    logic                         idx_last;
    logic [sfrc_pkg::DATA_W-1:0]  mode_eff;

    assign slot_free  = !ov_reg || m_tready;
    assign start_pair = (prev_reg == start_first) && (s_rx_byte == start_second);
    assign idx_last   = ((idx_reg + LEN_W'(1)) == len_reg);
    assign mode_eff   = (len_reg > LEN_W'(sfrc_pkg::POS_MODE)) ? mode_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        id_next    = id_reg;
        size_next  = size_reg;
        chk_next   = chk_reg;
        mode_next  = mode_reg;
        sts_next   = sts_reg;
        ob_next    = ob_reg;
        oi_next    = oi_reg;
        ol_next    = ol_reg;
        os_next    = os_reg;
        oid_next   = oid_reg;
        omode_next = omode_reg;
        ov_next    = ov_reg && !m_tready;
        len_acc    = len_reg;
        mem_we     = 1'b0;
        mem_waddr  = len_reg[AW-1:0];
        mem_wdata  = s_rx_byte;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[AW-1:0];
        acc_ctrl   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    prev_next = s_rx_byte;
                    if (start_pair)
                    begin
                        b0_next = prev_reg;
                        b1_next = s_rx_byte;
                        len_acc = LEN_W'(2);
                    end
                    else if (len_reg >= LEN_W'(2) && len_reg < LEN_W'(FRAME_MAX))
                    begin
                        mem_we  = 1'b1;
                        len_acc = len_reg + LEN_W'(1);
                        if (len_reg == LEN_W'(sfrc_pkg::POS_ID))
                        begin
                            id_next = s_rx_byte;
                        end
                        if (len_reg == LEN_W'(sfrc_pkg::POS_SIZE))
                        begin
                            size_next = s_rx_byte;
                        end
                        if (len_reg == LEN_W'(sfrc_pkg::POS_CHK))
                        begin
                            chk_next = s_rx_byte;
                        end
                        if (len_reg == LEN_W'(sfrc_pkg::POS_MODE))
                        begin
                            mode_next = s_rx_byte;
                        end
                    end
                    len_next = len_acc;
                    if (len_acc > LEN_W'(sfrc_pkg::HDR_LEN) &&
                        ({1'b0, size_reg} + SUM_W'(sfrc_pkg::HDR_LEN)) == SUM_W'(len_acc))
                    begin
                        idx_next     = LEN_W'(sfrc_pkg::POS_ID);
                        acc_ctrl.clr = 1'b1;
                        state_next   = S_SUM_RD;
                    end
                    else if (len_acc == LEN_W'(FRAME_MAX))
                    begin
                        sts_next   = sfrc_pkg::ST_OVERFLOW;
                        state_next = S_STATUS;
                    end
                end
            end

            S_SUM_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SUM_ADD;
            end

            S_SUM_ADD:
            begin
                // leave the checksum byte itself out of the sum
                acc_ctrl.add = (idx_reg != LEN_W'(sfrc_pkg::POS_CHK));
                if (idx_last)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = S_SUM_RD;
                end
            end

            S_CHECK:
            begin
                if (acc_match)
                begin
                    idx_next   = '0;
                    state_next = S_READ;
                end
                else
                begin
                    sts_next   = sfrc_pkg::ST_CHKSUM;
                    state_next = S_STATUS;
                end
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    oi_next    = sfrc_pkg::IDX_W'(idx_reg);
                    ol_next    = idx_last;
                    os_next    = sfrc_pkg::ST_GOOD;
                    oid_next   = id_reg;
                    omode_next = mode_eff;
                    if (idx_reg == LEN_W'(0))
                    begin
                        ob_next = b0_reg;
                    end
                    else if (idx_reg == LEN_W'(1))
                    begin
                        ob_next = b1_reg;
                    end
                    else
                    begin
                        ob_next = mem_rdata;
                    end
                    if (idx_last)
                    begin
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = S_READ;
                    end
                end
            end

            S_STATUS:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = '0;
                    oi_next    = '0;
                    ol_next    = 1'b1;
                    os_next    = sts_reg;
                    oid_next   = id_reg;
                    omode_next = mode_eff;
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prev_reg  <= '0;
            len_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        id_reg    <= id_next;
        size_reg  <= size_next;
        chk_reg   <= chk_next;
        mode_reg  <= mode_next;
        sts_reg   <= sts_next;
        ob_reg    <= ob_next;
        oi_reg    <= oi_next;
        ol_reg    <= ol_next;
        os_reg    <= os_next;
        oid_reg   <= oid_next;
        omode_reg <= omode_next;
    end

    assign s_tready     = (state_reg == S_IDLE);
    assign acc_chk      = chk_reg;
    assign m_tvalid     = ov_reg;
    assign m_frame_byte = ob_reg;
    assign m_byte_index = oi_reg;
    assign m_tlast      = ol_reg;
    assign m_status     = os_reg;
    assign m_device_id  = oid_reg;
    assign m_frame_mode = omode_reg;

endmodule

// File: rtl/core/serial_frame_receiver_checksum_top.sv
// A byte that does not close a frame is taken while the receiver is idle.
// A frame that closes has its bytes from the ID byte on summed through the shared adder (one
// store read, then one add, per byte), is checked, then emits each beat with a store read and
// an output load. Status beat: follows the check on a bad checksum, or the store-filling byte on overflow.
// s_tready is low while a frame is summed or emitted; the output register lets the next byte in
// while the final beat waits. Reset (rst_n, async low) closes any frame and restores start bytes.
module serial_frame_receiver_checksum_top #(
    parameter int FRAME_MAX = sfrc_pkg::FRAME_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [21:14] device_id,
                                   // [29:22] frame_mode, [31:30] zero
    output logic        m_tlast,   // last
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = $clog2(FRAME_MAX);

    logic [7:0]                  first_reg;
    logic [7:0]                  second_reg;
    logic                        cfg_wr;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [7:0]                  mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [7:0]                  mem_rdata;
    sfrc_pkg::acc_ctrl_t         acc_ctrl;
    logic [7:0]                  acc_chk;
    logic                        acc_match;

    logic [7:0]                  frame_byte;
    logic [5:0]                  byte_index;
    sfrc_pkg::status_t           status;
    logic [7:0]                  device_id;
    logic [7:0]                  frame_mode;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= sfrc_pkg::START_FIRST_RST;
            second_reg <= sfrc_pkg::START_SECOND_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                sfrc_pkg::REG_START_FIRST:  first_reg  <= pwdata[7:0];
                sfrc_pkg::REG_START_SECOND: second_reg <= pwdata[7:0];
                default:                    first_reg  <= first_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sfrc_pkg::REG_START_FIRST:  prdata = {24'b0, first_reg};
            sfrc_pkg::REG_START_SECOND: prdata = {24'b0, second_reg};
            default:                    prdata = '0;
        endcase
    end

    sfrc_ctrl #(
        .FRAME_MAX (FRAME_MAX)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_first  (first_reg),
        .start_second (second_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_rx_byte    (s_tdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .acc_ctrl     (acc_ctrl),
        .acc_chk      (acc_chk),
        .acc_match    (acc_match),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_frame_byte (frame_byte),
        .m_byte_index (byte_index),
        .m_tlast      (m_tlast),
        .m_status     (status),
        .m_device_id  (device_id),
        .m_frame_mode (frame_mode)
    );

    sfrc_store #(
        .FRAME_MAX (FRAME_MAX)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sfrc_acc u_acc (
        .clk     (clk),
        .ctrl    (acc_ctrl),
        .operand (mem_rdata),
        .chk     (acc_chk),
        .match   (acc_match)
    );

    assign m_tdata = {2'b00, frame_mode, device_id, byte_index, frame_byte};
    assign m_tuser = status;

endmodule

// File: rtl/core/sfrc_checker.sv
`include "serial_frame_receiver_checksum_top_defines.svh"

module sfrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    `SFRC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output beat changed while stalled")

    `SFRC_ASSERT_IMP(a_status_beat, m_tvalid && (m_tuser != 2'd0), m_tlast && (m_tdata[13:0] == 14'd0) && (m_tuser != 2'd3), "status beat not a single zero beat")

    `SFRC_ASSERT_IMP(a_busy_mid_frame, m_tvalid && !m_tlast, !s_tready, "input taken while a frame is still being emitted")

endmodule

bind serial_frame_receiver_checksum_top sfrc_checker u_sfrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: test/testbench.sv
module testbench;

    localparam int FRAME_LEN = sfrc_pkg::FRAME_MAX_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_OVERFLOW,
        FR_CUT,
        FR_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] index;
        logic       last;
        logic [1:0] status;
        logic [7:0] id;
        logic [7:0] mode;
    } frame_beat_t;

    class frame_scoreboard;
        logic [7:0]  first_start;
        logic [7:0]  second_start;
        logic [7:0]  prev_rx;
        int unsigned fill;
        logic [7:0]  store [FRAME_LEN];
        frame_beat_t expected [$];
        int unsigned mismatches;
        int unsigned beats_seen;

        function new();
            first_start = sfrc_pkg::START_FIRST_RST;
            second_start = sfrc_pkg::START_SECOND_RST;
            prev_rx = 8'h00;
            fill = 0;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void set_start(logic idx, logic [7:0] value);
            if (idx == sfrc_pkg::REG_START_FIRST)
                first_start = value;
            else
                second_start = value;
        endfunction

        function void add_beat(logic [7:0] fbyte, int unsigned idx, logic last,
                               sfrc_pkg::status_t status);
            frame_beat_t beat;
            beat.frame_byte = fbyte;
            beat.index = idx[5:0];
            beat.last = last;
            beat.status = status;
            beat.id = store[sfrc_pkg::POS_ID];
            beat.mode = (fill > sfrc_pkg::POS_MODE) ? store[sfrc_pkg::POS_MODE] : 8'h00;
            expected = {expected, beat};
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] sum;
            logic [7:0] chk;
            int unsigned i;
            if (prev_rx == first_start && b == second_start) begin
                store[0] = prev_rx;
                store[1] = b;
                fill = 2;
            end
            else if (fill >= 2 && fill < FRAME_LEN) begin
                store[fill] = b;
                fill++;
            end
            if (fill > sfrc_pkg::HDR_LEN &&
                int'(store[sfrc_pkg::POS_SIZE]) + sfrc_pkg::HDR_LEN == fill) begin
                sum = 8'h00;
                for (i = sfrc_pkg::POS_ID; i < fill; i++)
                    if (i != sfrc_pkg::POS_CHK)
                        sum = sum + store[i];
                chk = ~sum;
                if (chk == store[sfrc_pkg::POS_CHK]) begin
                    for (i = 0; i < fill; i++)
                        add_beat(store[i], i, (i + 1 == fill), sfrc_pkg::ST_GOOD);
                end
                else begin
                    add_beat(8'h00, 0, 1'b1, sfrc_pkg::ST_CHKSUM);
                end
                fill = 0;
            end
            if (fill == FRAME_LEN) begin
                add_beat(8'h00, 0, 1'b1, sfrc_pkg::ST_OVERFLOW);
                fill = 0;
            end
            prev_rx = b;
        endfunction

        function void check_result(logic [31:0] data, logic tlast, logic [1:0] user);
            frame_beat_t got;
            frame_beat_t want;
            got.frame_byte = data[7:0];
            got.index = data[13:8];
            got.last = tlast;
            got.status = user;
            got.id = data[21:14];
            got.mode = data[29:22];
            beats_seen++;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d unexpected: byte %h idx %0d last %b status %0d id %h mode %h",
                             beats_seen, got.frame_byte, got.index, got.last, got.status,
                             got.id, got.mode);
                return;
            end
            want = expected.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"beat %0d: expected byte %h idx %0d last %b status %0d id %h ",
                              "mode %h, got byte %h idx %0d last %b status %0d id %h mode %h"},
                             beats_seen, want.frame_byte, want.index, want.last, want.status,
                             want.id, want.mode, got.frame_byte, got.index, got.last,
                             got.status, got.id, got.mode);
            end
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] frame_byte, [13:8] byte_index, [21:14] device_id,
                            // [29:22] frame_mode
    logic        m_tlast;   // last
    logic [1:0]  m_tuser;   // [1:0] status

    frame_scoreboard frames;
    logic [7:0]      rx_bytes [$];
    logic [7:0]      cur_first;
    logic [7:0]      cur_second;
    bit              steady;
    int unsigned     quiet_cycles;

    serial_frame_receiver_checksum_top #(
        .FRAME_MAX (FRAME_LEN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Build one frame with the current start pair; bad checksum frames carry a flipped check
    // byte, overflow and cut frames a random one.
    function automatic void queue_frame(frame_kind_t kind, logic [7:0] id, logic [7:0] size);
        logic [7:0] rest [$];
        logic [7:0] sum;
        logic [7:0] chk;
        int count;
        case (kind)
            FR_OVERFLOW: count = FRAME_LEN - 5;
            FR_CUT:      count = $urandom_range(0, 6);
            default:     count = int'(size) - 1;
        endcase
        sum = id + size;
        for (int i = 0; i < count; i++)
        begin
            rest = {rest, 8'($urandom)};
            sum = sum + rest[i];
        end
        chk = ~sum;
        if (kind == FR_BAD_SUM)
            chk = chk ^ 8'($urandom_range(1, 255));
        else if (kind == FR_OVERFLOW || kind == FR_CUT)
            chk = 8'($urandom);
        rx_bytes = {rx_bytes, cur_first, cur_second, id, size, chk};
        foreach (rest[i])
            rx_bytes = {rx_bytes, rest[i]};
    endfunction

    task automatic send_byte(logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        frames.note_byte(b);
    endtask

    task automatic send_queued();
        while (rx_bytes.size() != 0)
            send_byte(rx_bytes.pop_front());
    endtask

    // Drop valid and wait until every expected beat is out, then let the last
    // byte settle before touching registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (frames.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        frames.set_start(idx, value);
        if (idx == sfrc_pkg::REG_START_FIRST)
            cur_first = value;
        else
            cur_second = value;
        @(posedge clk);
    endtask

    task automatic run_traffic(int unsigned target);
        int unsigned sent;
        int unsigned pick;
        frame_kind_t kind;
        logic [7:0] size;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                kind = FR_GOOD;
            else if (pick < 67)
                kind = FR_BAD_SUM;
            else if (pick < 77)
                kind = FR_OVERFLOW;
            else if (pick < 87)
                kind = FR_CUT;
            else
                kind = FR_NOISE;
            case (kind)
                FR_OVERFLOW: size = ($urandom_range(0, 3) == 0) ? 8'h00
                                    : 8'($urandom_range(FRAME_LEN - 3, 255));
                FR_CUT:      size = 8'($urandom_range(8, FRAME_LEN - 4));
                default:     size = 8'($urandom_range(1, FRAME_LEN - 4));
            endcase
            if (kind == FR_NOISE)
            begin
                repeat ($urandom_range(1, 4)) rx_bytes = {rx_bytes, 8'($urandom)};
            end
            else
            begin
                queue_frame(kind, 8'($urandom), size);
                // restart inside the open frame
                if (kind == FR_CUT)
                    queue_frame(FR_GOOD, 8'($urandom), 8'($urandom_range(1, FRAME_LEN - 4)));
            end
            sent += rx_bytes.size();
            send_queued();
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                frames.check_result(m_tdata, m_tlast, m_tuser);
            m_tready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        frames = new();
        cur_first = sfrc_pkg::START_FIRST_RST;
        cur_second = sfrc_pkg::START_SECOND_RST;
        steady = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'b000;
        pwdata <= 32'h0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte, short frames good and bad, restart, frame filling FRAME_MAX
        rx_bytes = {rx_bytes, 8'h00};
        queue_frame(FR_GOOD, 8'hFF, 8'h01);
        queue_frame(FR_BAD_SUM, 8'h00, 8'h01);
        queue_frame(FR_CUT, 8'h5A, 8'(FRAME_LEN - 4));
        queue_frame(FR_GOOD, 8'h00, 8'(FRAME_LEN - 4));
        send_queued();
        queue_frame(FR_OVERFLOW, 8'hA5, 8'hFF);
        send_queued();
        settle();

        steady = 1'b1;
        run_traffic(50);
        steady = 1'b0;
        settle();

        write_reg(sfrc_pkg::REG_START_FIRST, 8'h00);
        write_reg(sfrc_pkg::REG_START_SECOND, 8'h00);
        run_traffic(45);
        settle();

        write_reg(sfrc_pkg::REG_START_FIRST, 8'hFF);
        write_reg(sfrc_pkg::REG_START_SECOND, 8'hFF);
        run_traffic(45);
        settle();

        write_reg(sfrc_pkg::REG_START_SECOND, 8'hAA);
        write_reg(sfrc_pkg::REG_START_FIRST, 8'h55);
        run_traffic(45);
        settle();

        write_reg(sfrc_pkg::REG_START_FIRST, 8'($urandom));
        write_reg(sfrc_pkg::REG_START_SECOND, 8'($urandom));
        run_traffic(45);
        settle();

        if (frames.mismatches == 0 && frames.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sfrc_pkg.sv
rtl/core/sfrc_store.sv
rtl/core/sfrc_acc.sv
rtl/core/sfrc_ctrl.sv
rtl/core/serial_frame_receiver_checksum_top.sv
rtl/core/sfrc_checker.sv
test/testbench.sv
